// File: hw/rtl/sssd_pkg.sv
// Shared types, codes and the segment table of the seven-segment scan display.
package sssd_pkg;

  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] CFG_DIGIT_ORDER = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_LIT_DIGITS  = 1'b1;

  localparam logic [1:0] OP_SHOW_NUMBER = 2'd0;
  localparam logic [1:0] OP_SHOW_CODES  = 2'd1;
  localparam logic [1:0] OP_SCAN_TICK   = 2'd2;

  localparam logic [7:0]  DIGIT_ORDER_RESET = 8'hE4;
  localparam logic [2:0]  LIT_DIGITS_RESET  = 3'd4;
  localparam logic [13:0] NUMBER_MAX        = 14'd9999;

  typedef struct packed {
    logic [1:0]  operation;
    logic [13:0] number;
    logic [3:0]  digit_0;
    logic [3:0]  digit_1;
    logic [3:0]  digit_2;
    logic [3:0]  digit_3;
    logic [3:0]  point_mask;
  } item_t;

  typedef struct packed {
    logic [31:0] frame;
    logic        frame_valid;
    logic [2:0]  slot;
  } result_t;

  // Segment byte for a display code; bit 7 (decimal point) is left clear.
  function automatic logic [7:0] seg_byte(input logic [3:0] code);
    logic [7:0] b;
    unique case (code)
      4'd0:    b = 8'h3F;
      4'd1:    b = 8'h06;
      4'd2:    b = 8'h5B;
      4'd3:    b = 8'h4F;
      4'd4:    b = 8'h66;
      4'd5:    b = 8'h6D;
      4'd6:    b = 8'h7D;
      4'd7:    b = 8'h07;
      4'd8:    b = 8'h7F;
      4'd9:    b = 8'h6F;
      4'd10:   b = 8'h40;
      4'd12:   b = 8'h63;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/seven_segment_scan_display.sv
// Seven-segment scan display controller: digit loading, segment store and frame output.
module seven_segment_scan_display (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [sssd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [sssd_pkg::CfgDataWidth-1:0]     cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  sssd_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output sssd_pkg::result_t                     result
);
  // This block drives a four-digit seven-segment display through a chain of
  // four 8-bit shift registers. A show-number transaction splits 0..9999
  // (larger values saturate to 9999) into decimal digits with all points off;
  // a show-codes transaction takes four codes (0-9, 10 minus, 11 blank,
  // 12 degree, 13-15 blank) and a decimal-point mask. Each digit's segment
  // byte is stored at the position that digit_order assigns to it; where two
  // digits map to the same position the higher-numbered digit wins. A scan
  // tick advances the slot 1,2,3,4,1,... and returns the 32-bit frame, first
  // byte sent in bits 31:24, with only lit_digits bytes driven and the rest
  // zero. Every transaction, including the unused operation code, produces
  // exactly one result. The block accepts one transaction per clock cycle
  // while the result side does not stall it; each result passes through the
  // input register and then the result register, with the digit split, table
  // lookup and store update done in the single logic stage between them.
  // Back-pressure on the result side stalls the input register, which, when
  // empty, can still take a new transaction while a result waits. Configuration
  // writes take effect at once and must only happen while the block is idle.
  import sssd_pkg::*;

  // Configuration registers.
  logic [7:0] digit_order;
  logic [2:0] lit_digits;

  // Input register.
  logic  s1_valid;
  item_t s1_item;

  // Display state.
  logic [7:0] store [4];
  logic [7:0] store_next [4];
  logic [1:0] scan_slot;
  logic [1:0] scan_slot_next;

  logic    advance;
  result_t result_next;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_order <= DIGIT_ORDER_RESET;
      lit_digits  <= LIT_DIGITS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIGIT_ORDER: digit_order <= cfg_data;
        CFG_LIT_DIGITS:  lit_digits  <= cfg_data[2:0];
        default:         ;
      endcase
    end
  end

  // Decimal split of the saturated number. Each quotient is a multiply by a
  // scaled reciprocal; the scale factors are chosen so the truncation is exact
  // over 0..9999.
  logic [13:0] num_sat;
  logic [26:0] prod_10;
  logic [27:0] prod_100;
  logic [28:0] prod_1000;
  logic [9:0]  quo_10;
  logic [6:0]  quo_100;
  logic [3:0]  quo_1000;
  logic [13:0] rem_0;
  logic [9:0]  rem_1;
  logic [6:0]  rem_2;

  assign num_sat   = (s1_item.number > NUMBER_MAX) ? NUMBER_MAX : s1_item.number;
  assign prod_10   = 27'(num_sat) * 27'd6554;
  assign prod_100  = 28'(num_sat) * 28'd10486;
  assign prod_1000 = 29'(num_sat) * 29'd16778;
  assign quo_10    = prod_10[25:16];
  assign quo_100   = prod_100[26:20];
  assign quo_1000  = prod_1000[27:24];
  assign rem_0     = num_sat - 14'(quo_10) * 14'd10;
  assign rem_1     = quo_10 - 10'(quo_100) * 10'd10;
  assign rem_2     = quo_100 - 7'(quo_1000) * 7'd10;

  logic [3:0] codes [4];
  logic [3:0] points;
  logic [7:0] bytes [4];
  logic       is_load;

  always_comb begin
    if (s1_item.operation == OP_SHOW_NUMBER) begin
      codes[0] = rem_0[3:0];
      codes[1] = rem_1[3:0];
      codes[2] = rem_2[3:0];
      codes[3] = quo_1000;
      points   = 4'b0000;
    end else begin
      codes[0] = s1_item.digit_0;
      codes[1] = s1_item.digit_1;
      codes[2] = s1_item.digit_2;
      codes[3] = s1_item.digit_3;
      points   = s1_item.point_mask;
    end
    is_load = (s1_item.operation == OP_SHOW_NUMBER) ||
              (s1_item.operation == OP_SHOW_CODES);
    for (int i = 0; i < 4; i++) begin
      bytes[i] = seg_byte(codes[i]) | {points[i], 7'b0};
    end
    for (int p = 0; p < 4; p++) begin
      store_next[p] = store[p];
    end
    // Later digits overwrite earlier ones that target the same position.
    if (is_load) begin
      for (int i = 0; i < 4; i++) begin
        store_next[digit_order[2*i +: 2]] = bytes[i];
      end
    end
  end

  // Frame assembly. In slot s the bytes at (4 - s - j) mod 4 for
  // j < lit count are driven; with the stored slot index this is a compare of
  // ~(slot_index + k) against the clamped count.
  logic [2:0] lit_count;
  logic [1:0] lit_rank [4];
  logic [31:0] frame;

  always_comb begin
    scan_slot_next = (s1_item.operation == OP_SCAN_TICK) ? scan_slot + 2'd1 : scan_slot;
    lit_count      = (lit_digits > 3'd4) ? 3'd4 : lit_digits;
    frame          = '0;
    for (int k = 0; k < 4; k++) begin
      lit_rank[k] = ~(scan_slot_next + 2'(k));
      if ({1'b0, lit_rank[k]} < lit_count) begin
        frame[31 - 8*k -: 8] = store[k];
      end
    end
    result_next.frame_valid = (s1_item.operation == OP_SCAN_TICK);
    result_next.frame       = result_next.frame_valid ? frame : 32'd0;
    result_next.slot        = {1'b0, scan_slot_next} + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      scan_slot    <= 2'd3;
      for (int p = 0; p < 4; p++) begin
        store[p] <= 8'h00;
      end
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
        scan_slot    <= scan_slot_next;
        for (int p = 0; p < 4; p++) begin
          store[p] <= store_next[p];
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  // A load transaction never carries a frame.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.frame_valid |-> result.frame == 32'd0)
    else $error("frame bits set on a load result");

  // The reported slot is always one of the four scan slots.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.slot != 3'd0) && (result.slot <= 3'd4))
    else $error("result slot out of range");

  // A retired scan tick moves the slot on by one.
  assert property (@(posedge clk) disable iff (rst)
    advance && (s1_item.operation == OP_SCAN_TICK) |=> scan_slot == $past(scan_slot) + 2'd1)
    else $error("scan slot did not advance on a tick");

  // The input side only stalls while an item waits on a blocked result.
  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> s1_valid && result_valid && !result_ready)
    else $error("input stalled without a blocked result");

  // The scan slot only changes when a transaction retires.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(scan_slot))
    else $error("scan slot changed without a transaction");

endmodule

// File: tb/tb_seven_segment_scan_display.sv
// Self-checking testbench for the seven-segment scan display controller.
`timescale 1ns / 1ps

module tb_seven_segment_scan_display;
  import sssd_pkg::*;

  // The package names the three defined operations; the fourth encoding must do nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Segment bytes for codes 15 down to 0. Codes 11 and 13..15 are blank.
  localparam logic [15:0][7:0] GLYPHS = {
    8'h00, 8'h00, 8'h00, 8'h63, 8'h00, 8'h40, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_write    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index    = '0;
  logic [CfgDataWidth-1:0]  cfg_data     = '0;
  logic                     item_valid   = 1'b0;
  logic                     item_ready;
  item_t                    item         = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  result_t                  result;

  // Shadow copy of the display state and of both registers.
  logic [7:0] shadow_segments [4];
  logic [1:0] shadow_slot;
  logic [7:0] shadow_order;
  logic [2:0] shadow_lit;

  item_t   items_to_send [$];
  result_t outputs_due   [$];

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_cycles_left  = 0;
  int error_count       = 0;
  int results_checked   = 0;
  int frames_checked    = 0;
  int settings_used     = 0;

  int idle_choice  [4] = '{0, 79, 0, 38};
  int stall_choice [4] = '{0, 0, 79, 38};

  seven_segment_scan_display u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Stores four codes with their decimal points at the positions that the digit
  // order selects. Digits are written in order 0 to 3, so when two digits map to
  // the same position the higher-numbered one wins, and untouched positions keep
  // their old byte.
  function automatic void load_codes(logic [3:0][3:0] codes, logic [3:0] points);
    logic [1:0] pos;
    for (int i = 0; i < 4; i++) begin
      pos = shadow_order[2*i +: 2];
      shadow_segments[pos] = GLYPHS[codes[i]] | {points[i], 7'b0};
    end
  endfunction

  // Builds the shift-chain frame for the current slot. In slot s the driven
  // store bytes are (4 - s - j) mod 4 for the first lit-count values of j; a lit
  // count of zero drives nothing, and counts above four act as four.
  function automatic logic [31:0] scan_frame();
    logic [31:0] frame_word;
    int          lit_count;
    int          idx;
    frame_word = '0;
    lit_count  = (shadow_lit > 3'd4) ? 4 : int'(shadow_lit);
    for (int j = 0; j < lit_count; j++) begin
      idx = (7 - int'(shadow_slot) - j) & 3;
      frame_word[31 - 8*idx -: 8] = shadow_segments[idx];
    end
    return frame_word;
  endfunction

  // Applies one transaction to the shadow state and returns the display output
  // that it should produce.
  function automatic result_t advance_display(item_t it);
    result_t         out_word;
    int              value;
    logic [3:0][3:0] digits;
    out_word = '0;
    case (it.operation)
      OP_SHOW_NUMBER: begin
        // Numbers beyond the four-digit range saturate, and all points go dark.
        value     = (it.number > NUMBER_MAX) ? int'(NUMBER_MAX) : int'(it.number);
        digits[0] = 4'(value % 10);
        digits[1] = 4'((value / 10) % 10);
        digits[2] = 4'((value / 100) % 10);
        digits[3] = 4'(value / 1000);
        load_codes(digits, 4'h0);
      end
      OP_SHOW_CODES: begin
        load_codes({it.digit_3, it.digit_2, it.digit_1, it.digit_0}, it.point_mask);
      end
      OP_SCAN_TICK: begin
        shadow_slot           = shadow_slot + 2'd1;
        out_word.frame        = scan_frame();
        out_word.frame_valid  = 1'b1;
      end
      default: begin
        // The unused operation leaves the state alone and reports the slot.
      end
    endcase
    out_word.slot = {1'b0, shadow_slot} + 3'd1;
    return out_word;
  endfunction

  // Every field gets fully random content, so every bit toggles whatever the
  // operation is; fields that an operation ignores must stay ignored.
  function automatic item_t random_fields(logic [1:0] op);
    item_t it;
    it.operation  = op;
    it.number     = 14'($urandom_range(1) ? $urandom_range(9999) : $urandom_range(16383));
    it.digit_0    = 4'($urandom_range(15));
    it.digit_1    = 4'($urandom_range(15));
    it.digit_2    = 4'($urandom_range(15));
    it.digit_3    = 4'($urandom_range(15));
    it.point_mask = 4'($urandom_range(15));
    return it;
  endfunction

  function automatic item_t number_item(logic [13:0] value);
    item_t it;
    it        = random_fields(OP_SHOW_NUMBER);
    it.number = value;
    return it;
  endfunction

  function automatic item_t codes_item(logic [3:0] d3, logic [3:0] d2, logic [3:0] d1,
                                       logic [3:0] d0, logic [3:0] points);
    item_t it;
    it            = random_fields(OP_SHOW_CODES);
    it.digit_3    = d3;
    it.digit_2    = d2;
    it.digit_1    = d1;
    it.digit_0    = d0;
    it.point_mask = points;
    return it;
  endfunction

  // Ticks dominate a little so that every slot is seen often after each load.
  function automatic item_t random_item();
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    if (pick < 38) begin
      op = OP_SCAN_TICK;
    end else if (pick < 63) begin
      op = OP_SHOW_NUMBER;
    end else if (pick < 93) begin
      op = OP_SHOW_CODES;
    end else begin
      op = OP_UNUSED;
    end
    return random_fields(op);
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Sender. A transaction completes at an edge where valid and ready are both
  // high; the expected output is computed right there. Valid is only dropped or
  // reloaded when nothing is being held on the bus.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        outputs_due.push_back(advance_display(item));
      end
      if (!item_valid || item_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item       <= items_to_send.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each completed output transaction is compared field by field with
  // the oldest outstanding prediction; ready is then re-rolled for the next edge.
  always @(posedge clk) begin : receiver
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (outputs_due.size() == 0) begin
          flag_error($sformatf("unexpected output %h", result));
        end else begin
          want = outputs_due.pop_front();
          results_checked++;
          if (want.frame_valid) begin
            frames_checked++;
          end
          if (result.frame !== want.frame) begin
            flag_error($sformatf("frame %h, predicted %h", result.frame, want.frame));
          end
          if (result.frame_valid !== want.frame_valid) begin
            flag_error($sformatf("frame_valid %b, predicted %b",
                                 result.frame_valid, want.frame_valid));
          end
          if (result.slot !== want.slot) begin
            flag_error($sformatf("slot %0d, predicted %0d", result.slot, want.slot));
          end
        end
      end
      result_ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Counts down a long receiver hold-off so that the block backs up and has to
  // stall its input while the sender keeps offering work.
  always @(posedge clk) begin
    if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  // Returns once everything queued has been accepted and answered, plus a
  // margin for the output register.
  task automatic wait_until_idle();
    while (items_to_send.size() != 0 || item_valid || outputs_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DIGIT_ORDER) begin
      shadow_order = data;
    end else begin
      shadow_lit = data[2:0];
    end
    @(negedge clk);
  endtask

  // One phase: drain, reprogram both registers, pick an idling mix, optionally
  // start a long receiver hold-off, then queue random traffic.
  task automatic run_phase(logic [7:0] order, logic [7:0] lit_data, int idle_pct,
                           int stall_pct, int item_count, int hold_cycles);
    wait_until_idle();
    write_register(CFG_DIGIT_ORDER, order);
    write_register(CFG_LIT_DIGITS, lit_data);
    settings_used++;
    send_idle_pct    = idle_pct;
    recv_stall_pct   = stall_pct;
    hold_cycles_left = hold_cycles;
    repeat (item_count) items_to_send.push_back(random_item());
  endtask

  initial begin
    int mode;
    for (int i = 0; i < 4; i++) begin
      shadow_segments[i] = 8'h00;
    end
    shadow_slot  = 2'd3;
    shadow_order = DIGIT_ORDER_RESET;
    shadow_lit   = LIT_DIGITS_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, still on the reset register values. The first tick must
    // show slot 1 with a blank store.
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(number_item(14'd1234));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(number_item(NUMBER_MAX));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    // Just past the limit and the all-ones value both saturate.
    items_to_send.push_back(number_item(14'd10000));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(number_item(14'h3FFF));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(number_item(14'd0));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    // Minus, blank, degree and an out-of-table code, all with points lit.
    items_to_send.push_back(codes_item(4'd13, 4'd12, 4'd11, 4'd10, 4'hF));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(codes_item(4'd6, 4'd5, 4'd15, 4'd14, 4'h5));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    // Showing a number must clear the points that the previous load set.
    items_to_send.push_back(number_item(14'd5678));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(codes_item(4'd0, 4'd9, 4'd8, 4'd7, 4'h0));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));
    items_to_send.push_back(random_fields(OP_UNUSED));
    items_to_send.push_back(random_fields(OP_SCAN_TICK));

    // Fixed settings cover the digit-order extremes (identity, reversed, every
    // digit on one position) and the lit counts zero, one, two, three and an
    // over-range value written with the upper data bits set.
    run_phase(8'hE4, 8'd2,  0,  0,  200, 0);
    run_phase(8'h1B, 8'd1,  79, 0,  200, 0);
    run_phase(8'h00, 8'd0,  0,  79, 180, 0);
    run_phase(8'hFF, 8'hFF, 38, 38, 180, 0);
    run_phase(8'h4E, 8'd3,  0,  0,  150, 400);

    // Short random phases with random settings and idling mixes.
    for (int c = 0; c < 6; c++) begin
      mode = $urandom_range(3);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), idle_choice[mode],
                stall_choice[mode], 40, 0);
    end

    wait_until_idle();
    repeat (8) @(negedge clk);

    $display("Checked %0d outputs, %0d of them scan frames, over %0d register settings.",
             results_checked, frames_checked, settings_used);
    $display("Traffic mixed free flow, sender gaps, receiver stalls and a long back-up.");
    if (error_count == 0 && outputs_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // A correct run ends far within this bound, even with the heaviest idling.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
